// ----- rtl/awds_pkg.sv -----
// ----------------------------------------------------------------------------
// awds_pkg
// Shared types, constants and helpers of the alpha-weighted 2x2 downsampler.
// ----------------------------------------------------------------------------
package awds_pkg;

    localparam int MAX_ROW_PIXELS_DEF = 64;

    localparam int PIX_W      = 32;
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int BPP_W      = 3;
    localparam int SW_W       = 7;
    localparam int CFG_DATA_W = 7;

    // sum of four channel bytes and sum of four byte products
    localparam int SUM_W  = 10;
    localparam int WSUM_W = 18;
    localparam int NUM_COLOR = 3;

    localparam int DIV_STEPS = 8;
    localparam int DIV_CNT_W = 3;

    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
    localparam logic [SW_W-1:0]  SW_RESET  = 7'd64;

    localparam logic [BPP_W-1:0] BPP_GRAY   = 3'd1;
    localparam logic [BPP_W-1:0] BPP_GRAY_A = 3'd2;
    localparam logic [BPP_W-1:0] BPP_RGB    = 3'd3;
    localparam logic [BPP_W-1:0] BPP_RGBA   = 3'd4;

    typedef enum logic [0:0] {
        REG_BPP       = 1'b0,
        REG_SRC_WIDTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_LEFT,
        ST_READ_RIGHT,
        ST_SUM,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic take;
        logic rd_left;
        logic rd_right;
        logic sum_en;
        logic div_en;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic block_done;
        logic out_free;
    } status_t;

    // out-of-range pixel sizes fold onto the nearest legal one
    function automatic logic [BPP_W-1:0] eff_bpp(input logic [BPP_W-1:0] raw);
        logic [BPP_W-1:0] res;
        begin
            if (raw == 3'd0)
            begin
                res = BPP_GRAY;
            end
            else if (raw > BPP_RGBA)
            begin
                res = BPP_RGBA;
            end
            else
            begin
                res = raw;
            end
            return res;
        end
    endfunction

endpackage

// ----- rtl/awds_in_if.sv -----
// ----------------------------------------------------------------------------
// awds_in_if
// Source pixel channel: valid/ready handshake with pixel and tile-start flag.
// ----------------------------------------------------------------------------
interface awds_in_if;
    logic                        valid;
    logic                        ready;
    logic [awds_pkg::PIX_W-1:0]  pixel_in;
    logic                        first_of_tile;

    modport source (output valid, output pixel_in, output first_of_tile, input ready);
    modport sink   (input valid, input pixel_in, input first_of_tile, output ready);
endinterface

// ----- rtl/awds_out_if.sv -----
// ----------------------------------------------------------------------------
// awds_out_if
// Downsampled pixel channel: valid/ready handshake with pixel and row end.
// ----------------------------------------------------------------------------
interface awds_out_if;
    logic                        valid;
    logic                        ready;
    logic [awds_pkg::PIX_W-1:0]  pixel_out;
    logic                        row_end;

    modport source (output valid, output pixel_out, output row_end, input ready);
    modport sink   (input valid, input pixel_out, input row_end, output ready);
endinterface

// ----- rtl/awds_ctrl.sv -----
// ----------------------------------------------------------------------------
// awds_ctrl
// Sequencer: takes items, walks block items through read, sum, divide, finish.
// ----------------------------------------------------------------------------
module awds_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  awds_pkg::status_t  status,
    output awds_pkg::cmd_t     cmd
);

    awds_pkg::state_t                 state_reg, state_next;
    logic [awds_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= awds_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            awds_pkg::ST_IDLE:
            begin
                if (in_valid && status.block_done)
                begin
                    state_next = awds_pkg::ST_READ_LEFT;
                end
            end
            awds_pkg::ST_READ_LEFT:
            begin
                state_next = awds_pkg::ST_READ_RIGHT;
            end
            awds_pkg::ST_READ_RIGHT:
            begin
                state_next = awds_pkg::ST_SUM;
            end
            awds_pkg::ST_SUM:
            begin
                state_next = awds_pkg::ST_DIVIDE;
                cnt_next   = awds_pkg::DIV_CNT_W'(awds_pkg::DIV_STEPS - 1);
            end
            awds_pkg::ST_DIVIDE:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = awds_pkg::ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg - awds_pkg::DIV_CNT_W'(1);
                end
            end
            awds_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = awds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = awds_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            awds_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.take = in_valid;
            end
            awds_pkg::ST_READ_LEFT:
            begin
                cmd.rd_left = 1'b1;
            end
            awds_pkg::ST_READ_RIGHT:
            begin
                cmd.rd_right = 1'b1;
            end
            awds_pkg::ST_SUM:
            begin
                cmd.sum_en = 1'b1;
            end
            awds_pkg::ST_DIVIDE:
            begin
                cmd.div_en = 1'b1;
            end
            awds_pkg::ST_FINISH:
            begin
                cmd.load_out = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- rtl/awds_dp.sv -----
// ----------------------------------------------------------------------------
// awds_dp
// Datapath: config registers, position tracking, line buffer, block sums,
// bit-serial alpha divide and the output register.
// ----------------------------------------------------------------------------
module awds_dp #(
    parameter int MAX_ROW_PIXELS = awds_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  awds_pkg::cfg_reg_t                cfg_index,
    input  logic [awds_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [awds_pkg::PIX_W-1:0]        pixel_in,
    input  logic                              first_of_tile,
    input  awds_pkg::cmd_t                    cmd,
    output awds_pkg::status_t                 status,
    output logic [awds_pkg::PIX_W-1:0]        pixel_out,
    output logic                              row_end,
    output logic                              out_valid,
    input  logic                              out_ready
);

    localparam int CW   = (MAX_ROW_PIXELS > 2) ? $clog2(MAX_ROW_PIXELS) : 1;
    localparam int CMPW = ((CW > awds_pkg::SW_W) ? CW : awds_pkg::SW_W) + 1;
    localparam logic [CMPW-1:0] MAX_W = CMPW'(MAX_ROW_PIXELS);
    localparam logic [CMPW-1:0] MIN_W = CMPW'(2);

    localparam int PW  = awds_pkg::PIX_W;
    localparam int CH  = awds_pkg::CHAN_W;
    localparam int SW  = awds_pkg::SUM_W;
    localparam int WSW = awds_pkg::WSUM_W;
    localparam int NCH = awds_pkg::NUM_CHAN;
    localparam int NCO = awds_pkg::NUM_COLOR;

    // configuration
    logic [awds_pkg::BPP_W-1:0] bpp_reg;
    logic [awds_pkg::SW_W-1:0]  sw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg <= awds_pkg::BPP_RESET;
            sw_reg  <= awds_pkg::SW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                awds_pkg::REG_BPP:       bpp_reg <= cfg_data[awds_pkg::BPP_W-1:0];
                awds_pkg::REG_SRC_WIDTH: sw_reg  <= cfg_data[awds_pkg::SW_W-1:0];
                default:                 bpp_reg <= bpp_reg;
            endcase
        end
    end

    logic [awds_pkg::BPP_W-1:0] bpp_e;
    logic                       alpha_mode;
    logic [CMPW-1:0]            sw_ext;
    logic [CMPW-1:0]            w_eff;

    always_comb
    begin
        bpp_e      = awds_pkg::eff_bpp(bpp_reg);
        alpha_mode = (bpp_e == awds_pkg::BPP_GRAY_A) || (bpp_e == awds_pkg::BPP_RGBA);
        sw_ext     = CMPW'(sw_reg);
        if (sw_ext < MIN_W)
        begin
            w_eff = MIN_W;
        end
        else if (sw_ext > MAX_W)
        begin
            w_eff = MAX_W;
        end
        else
        begin
            w_eff = sw_ext;
        end
    end

    // position tracking
    logic [CW-1:0]   col_reg;
    logic            bottom_reg;
    logic [PW-1:0]   left_reg;
    logic [CW-1:0]   col_cur;
    logic            bottom_cur;
    logic [CMPW-1:0] col_inc;
    logic            row_done;
    logic            mem_we;

    always_comb
    begin
        col_cur    = first_of_tile ? '0 : col_reg;
        bottom_cur = first_of_tile ? 1'b0 : bottom_reg;
        col_inc    = CMPW'(col_cur) + CMPW'(1);
        row_done   = (col_inc >= w_eff);
        mem_we     = cmd.take && !bottom_cur;
    end

    assign status.block_done = bottom_cur && col_cur[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            bottom_reg <= 1'b0;
            left_reg   <= '0;
        end
        else if (cmd.take)
        begin
            col_reg    <= row_done ? '0 : col_inc[CW-1:0];
            bottom_reg <= row_done ? !bottom_cur : bottom_cur;
            if (bottom_cur && !col_cur[0])
            begin
                left_reg <= pixel_in;
            end
        end
    end

    // block item capture
    logic [PW-1:0] px_reg;
    logic [CW-1:0] c_reg;
    logic          row_end_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.take && status.block_done)
        begin
            px_reg      <= pixel_in;
            c_reg       <= col_cur;
            row_end_reg <= (col_inc >= {w_eff[CMPW-1:1], 1'b0});
        end
    end

    // top row line buffer
    logic [PW-1:0] mem [MAX_ROW_PIXELS];
    logic [PW-1:0] rdata_reg;
    logic [PW-1:0] q0_reg;
    logic [CW-1:0] rd_addr;

    assign rd_addr = cmd.rd_left ? (c_reg - CW'(1)) : c_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[col_cur] <= pixel_in;
        end
        if (cmd.rd_left || cmd.rd_right)
        begin
            rdata_reg <= mem[rd_addr];
        end
        if (cmd.rd_right)
        begin
            q0_reg <= rdata_reg;
        end
    end

    // block sums
    logic [PW-1:0]  quad [4];
    logic [CH-1:0]  alpha [4];
    logic [SW-1:0]  psum [NCH];
    logic [WSW-1:0] wsum [NCO];

    always_comb
    begin
        quad[0] = q0_reg;
        quad[1] = rdata_reg;
        quad[2] = left_reg;
        quad[3] = px_reg;
        for (int n = 0; n < 4; n++)
        begin
            alpha[n] = (bpp_e == awds_pkg::BPP_GRAY_A) ? quad[n][2*CH-1:CH]
                                                        : quad[n][4*CH-1:3*CH];
        end
        for (int k = 0; k < NCH; k++)
        begin
            psum[k] = '0;
            for (int n = 0; n < 4; n++)
            begin
                psum[k] = psum[k] + SW'(quad[n][k*CH +: CH]);
            end
        end
        for (int k = 0; k < NCO; k++)
        begin
            wsum[k] = '0;
            for (int n = 0; n < 4; n++)
            begin
                wsum[k] = wsum[k] + (WSW'(quad[n][k*CH +: CH]) * WSW'(alpha[n]));
            end
        end
    end

    logic [SW-1:0]  psum_reg [NCH];
    logic [SW-1:0]  asum_reg;
    logic [WSW-1:0] rem_reg [NCO];
    logic [CH-1:0]  quo_reg [NCO];

    // restoring divide, one quotient bit per cycle, msb first
    logic [awds_pkg::DIV_CNT_W-1:0] div_sh;
    logic [WSW-1:0]                 dvs;
    logic [WSW-1:0]                 rem_diff [NCO];
    logic                           rem_ge [NCO];

    always_comb
    begin
        dvs = WSW'(asum_reg) << div_sh;
        for (int k = 0; k < NCO; k++)
        begin
            rem_ge[k]   = (rem_reg[k] >= dvs);
            rem_diff[k] = rem_reg[k] - dvs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            for (int k = 0; k < NCH; k++)
            begin
                psum_reg[k] <= psum[k];
            end
            for (int k = 0; k < NCO; k++)
            begin
                rem_reg[k] <= wsum[k];
            end
            asum_reg <= (bpp_e == awds_pkg::BPP_GRAY_A) ? psum[1] : psum[3];
            div_sh   <= awds_pkg::DIV_CNT_W'(awds_pkg::DIV_STEPS - 1);
        end
        else if (cmd.div_en)
        begin
            for (int k = 0; k < NCO; k++)
            begin
                if (rem_ge[k])
                begin
                    rem_reg[k] <= rem_diff[k];
                end
                quo_reg[k] <= {quo_reg[k][CH-2:0], rem_ge[k]};
            end
            div_sh <= div_sh - awds_pkg::DIV_CNT_W'(1);
        end
    end

    // result assembly
    logic [PW-1:0] res;

    always_comb
    begin
        res = '0;
        unique case (bpp_e)
            awds_pkg::BPP_GRAY:
            begin
                res[CH-1:0] = psum_reg[0][SW-1:2];
            end
            awds_pkg::BPP_RGB:
            begin
                res[CH-1:0]      = psum_reg[0][SW-1:2];
                res[2*CH-1:CH]   = psum_reg[1][SW-1:2];
                res[3*CH-1:2*CH] = psum_reg[2][SW-1:2];
            end
            awds_pkg::BPP_GRAY_A:
            begin
                if (asum_reg != '0)
                begin
                    res[CH-1:0]    = quo_reg[0];
                    res[2*CH-1:CH] = asum_reg[SW-1:2];
                end
            end
            default:
            begin
                if (asum_reg != '0)
                begin
                    res[CH-1:0]      = quo_reg[0];
                    res[2*CH-1:CH]   = quo_reg[1];
                    res[3*CH-1:2*CH] = quo_reg[2];
                    res[4*CH-1:3*CH] = asum_reg[SW-1:2];
                end
            end
        endcase
        if (!alpha_mode && (bpp_e == awds_pkg::BPP_GRAY_A))
        begin
            res = '0;
        end
    end

    // output register
    logic          out_valid_reg;
    logic [PW-1:0] out_pix_reg;
    logic          out_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_pix_reg <= res;
            out_end_reg <= row_end_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign pixel_out       = out_pix_reg;
    assign row_end         = out_end_reg;

endmodule

// ----- rtl/alpha_weighted_2x2_downsample_core.sv -----
// ----------------------------------------------------------------------------
// alpha_weighted_2x2_downsample_core
// Half-size 2x2 box downsampler with alpha-weighted colour averaging.
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  pixels    sink       valid/ready    pixel_in[31:0], first_of_tile
//  results   source     valid/ready    pixel_out[31:0], row_end
//  cfg       sink       cfg_we         cfg_index (0 bpp, 1 width), cfg_data[6:0]
//
//  an item that completes no 2x2 block is taken while the sequencer stays idle
//  an item on an odd bottom-row column goes through two line buffer reads
//  on its single port, one sum step and an 8-step bit-serial alpha divide
//  the result sits in an output register; the next item is taken while it waits
//  a full output register stalls only the next block item, in its last cycle
//  rst_n clears position and output valid and sets config to its defaults at once; no clearing pass
// ----------------------------------------------------------------------------
module alpha_weighted_2x2_downsample_core #(
    parameter int MAX_ROW_PIXELS = awds_pkg::MAX_ROW_PIXELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    awds_in_if.sink                          pixels,
    awds_out_if.source                       results,
    input  logic                             cfg_we,
    input  awds_pkg::cfg_reg_t               cfg_index,
    input  logic [awds_pkg::CFG_DATA_W-1:0]  cfg_data
);

    awds_pkg::cmd_t    cmd;
    awds_pkg::status_t status;

    awds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixels.valid),
        .in_ready (pixels.ready),
        .status   (status),
        .cmd      (cmd)
    );

    awds_dp #(
        .MAX_ROW_PIXELS (MAX_ROW_PIXELS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_in      (pixels.pixel_in),
        .first_of_tile (pixels.first_of_tile),
        .cmd           (cmd),
        .status        (status),
        .pixel_out     (results.pixel_out),
        .row_end       (results.row_end),
        .out_valid     (results.valid),
        .out_ready     (results.ready)
    );

endmodule

// ----- rtl/awds_checker.sv -----
// ----------------------------------------------------------------------------
// awds_checker
// Port-level checks of the downsampler, bound to the top level.
// ----------------------------------------------------------------------------
module awds_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [awds_pkg::PIX_W-1:0]   pixel_out,
    input logic                         row_end
);

    // result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_out) && $stable(row_end))
        else $error("result payload changed while stalled");

    // nothing is shown during reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // a new result only appears after the block's divide, never right on a take
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared right after an item was taken");

endmodule

bind alpha_weighted_2x2_downsample_core awds_checker u_awds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pixels.valid),
    .in_ready  (pixels.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .pixel_out (results.pixel_out),
    .row_end   (results.row_end)
);
